@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ hdl/jacm_pkg.sv @@
// Package: constants and types of the joystick calibrate and map block.
package jacm_pkg;
  localparam int AdcBits   = 12;
  localparam int FullScale = 1000;
  localparam int CmdBits   = 11;
  localparam int FracBits  = 16;
  localparam int LpK       = 655;
  localparam int Lopsided  = 10;
  localparam int DivBits   = 32;

  localparam logic [0:0] CfgHold = 1'b0;
  localparam logic [0:0] CfgGap  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SPEED, ST_STEER, ST_DIV, ST_OUT
  } state_e;
endpackage

@@ hdl/jacm_div.sv @@
// Shared iterative signed divider, one quotient bit per cycle, truncating.
module jacm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [jacm_pkg::DivBits-1:0] num_i,
  input  logic signed [jacm_pkg::DivBits-1:0] den_i,
  output logic                                busy_o,
  output logic signed [jacm_pkg::DivBits-1:0] quo_o
);
  import jacm_pkg::*;
  localparam int CntW = $clog2(DivBits + 1);
  logic [DivBits-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic               neg_q, neg_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivBits:0]   trial;
  logic [DivBits-1:0] shrem;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q; cnt_d = cnt_q;
    shrem = {rem_q[DivBits-2:0], quo_q[DivBits-1]};
    trial = {1'b0, shrem} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i[DivBits-1] ? DivBits'(-num_i) : num_i;
      den_d = den_i[DivBits-1] ? DivBits'(-den_i) : den_i;
      neg_d = num_i[DivBits-1] ^ den_i[DivBits-1];
      cnt_d = CntW'(DivBits);
    end else if (cnt_q != '0) begin
      if (!trial[DivBits]) begin
        rem_d = trial[DivBits-1:0];
        quo_d = {quo_q[DivBits-2:0], 1'b1};
      end else begin
        rem_d = shrem;
        quo_d = {quo_q[DivBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

@@ hdl/joystick_adc_calibrate_map.sv @@
// Top level: joystick converter calibration and piecewise-linear mapping.
//
//  channel  | dir | tdata bits (lowest first)                         | tuser
//  s_axis   | in  | speed_adc[11:0] steer_adc[23:12] now_ms[55:24]     | req_type
//  m_axis   | out | speed_cmd, steer_cmd, cal_step, cal_done, 6 x cal  | -
//  cfg      | in  | 0 = hold_ms, 1 = gap_ms                            | -
//
// A normal-mode transfer has a decode cycle, then one shared 32-bit divider
// runs twice (speed then steer), each run a load cycle, the quotient bits and
// a read-out cycle. Calibration and begin items return to idle after decoding.
// The input is not ready while an item is at work or its result waits in the
// output register. Reset restores the stored calibration to center 2048,
// max 4095, min 0. A stalled output holds its result and blocks input.
module joystick_adc_calibrate_map (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [55:0]  s_axis_tdata,  // speed_adc, steer_adc, now_ms
  input  logic         s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // speed_cmd, steer_cmd, cal_step, cal_done,
                                      // spd neutral/max/min, str neutral/max/min
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);
  import jacm_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = 12;
  localparam logic [27:0] MidQ = 28'(2048) << FracBits;

  state_e state_q, state_d;
  logic [15:0] hold_q, gap_q;
  logic [2:0]  step_q;
  logic [27:0] fsp_q, fst_q;
  logic [31:0] sdl_q, gdl_q;
  logic        gw_q;
  logic [AW-1:0] sn_q, sx_q, sm_q, tn_q, tx_q, tm_q;
  logic signed [10:0] hs_q, ht_q;
  logic        done_q;
  logic [55:0] in_q;
  logic        req_q;
  logic        ovalid_q;
  // mapping scratch
  logic signed [14:0] d_q;
  logic signed [14:0] rng_q;
  logic               axis_q; // 0 speed, 1 steer
  logic signed [14:0] d_n, r_n;

  logic div_start, div_busy;
  logic signed [31:0] div_quo;
  jacm_div u_div (.clk_i, .rst_ni, .start_i(div_start),
    .num_i(32'(d_n) * 32'sd1000), .den_i(32'(r_n)), .busy_o(div_busy), .quo_o(div_quo));

  wire [11:0] sp  = in_q[11:0];
  wire [11:0] st  = in_q[23:12];
  wire [31:0] now = in_q[55:24];

  function automatic logic [27:0] lp(input logic [27:0] f, input logic [11:0] x);
    logic [63:0] a;
    a = 64'(f) * 64'(65536 - LpK) + (64'(x) << 16) * 64'(LpK) + 64'd32768;
    return a[43:16];
  endfunction
  function automatic logic [11:0] lat(input logic [27:0] f);
    return f[27:16];
  endfunction
  function automatic logic signed [10:0] clampf(input logic signed [31:0] v);
    if (v > 32'sd1000) return 11'sd1000;
    if (v < -32'sd1000) return -11'sd1000;
    return v[10:0];
  endfunction

  // setup: compute d and range for one axis
  logic [11:0] xs;
  always_comb begin
    xs = sp;
    if (sp < sm_q) xs = sm_q; else if (sp > sx_q) xs = sx_q;
    if (state_q == ST_SPEED) begin
      d_n = $signed({3'b0, xs}) - $signed({3'b0, sn_q});
      r_n = (xs >= sn_q) ? $signed({3'b0, sx_q}) - $signed({3'b0, sn_q})
                         : $signed({3'b0, sn_q}) - $signed({3'b0, sm_q});
    end else begin
      d_n = $signed({3'b0, st}) - $signed({3'b0, tn_q});
      r_n = (st >= tn_q) ? $signed({3'b0, tx_q}) - $signed({3'b0, tn_q})
                         : $signed({3'b0, tn_q}) - $signed({3'b0, tm_q});
    end
  end

  logic signed [10:0] mapped;
  always_comb begin
    if (rng_q == 0) mapped = (d_q > 0) ? 11'sd1000 : ((d_q < 0) ? -11'sd1000 : 11'sd0);
    else mapped = clampf(div_quo);
  end

  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  wire acc = s_axis_tvalid && s_axis_tready;
  assign div_start = (state_q == ST_SPEED || state_q == ST_STEER);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (acc) state_d = ST_OUT;
      ST_OUT:   state_d = (!req_q && step_q == 3'd0) ? ST_SPEED : ST_IDLE;
      ST_SPEED: state_d = ST_DIV;
      ST_STEER: state_d = ST_DIV;
      ST_DIV:   if (!div_busy && !div_start) state_d = axis_q ? ST_IDLE : ST_STEER;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; hold_q <= 16'd5000; gap_q <= 16'd2000;
      step_q <= '0; fsp_q <= MidQ; fst_q <= MidQ; sdl_q <= '0; gdl_q <= '0;
      gw_q <= 1'b0; sn_q <= 12'd2048; sx_q <= 12'd4095; sm_q <= '0;
      tn_q <= 12'd2048; tx_q <= 12'd4095; tm_q <= '0; hs_q <= '0; ht_q <= '0;
      done_q <= 1'b0; ovalid_q <= 1'b0; axis_q <= 1'b0; req_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHold) hold_q <= cfg_wdata_i; else gap_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      if (acc) begin
        req_q <= s_axis_tuser; done_q <= 1'b0;
      end
      case (state_q)
        ST_OUT: begin
          if (req_q) begin
            step_q <= 3'd1; fsp_q <= MidQ; fst_q <= MidQ; gw_q <= 1'b0;
            gdl_q <= '0; sdl_q <= now + 32'(hold_q); ovalid_q <= 1'b1;
          end else if (step_q == 3'd0) begin
            axis_q <= 1'b0;
          end else if (step_q > 3'd5) begin
            step_q <= '0; ovalid_q <= 1'b1;
          end else begin
            ovalid_q <= 1'b1;
            if (!(gw_q && now < gdl_q)) begin : run
              logic [31:0] dl;
              logic [27:0] nfs, nft;
              logic signed [16:0] rmax, rmin;
              logic        adv;
              // end the pause and restart the hold time
              dl = gw_q ? now + 32'(hold_q) : sdl_q;
              sdl_q <= dl;
              nfs = (step_q <= 3'd3) ? lp(fsp_q, sp) : fsp_q;
              nft = (step_q == 3'd1 || step_q >= 3'd4) ? lp(fst_q, st) : fst_q;
              rmax = 17'($signed({1'b0, sx_q})) - 17'($signed({1'b0, sn_q}));
              rmin = 17'($signed({1'b0, sn_q})) - 17'($signed({1'b0, sm_q}));
              // advance with a pause after every step but the last
              adv = (now > dl) && (step_q != 3'd5);
              gw_q <= adv;
              if (adv) begin
                fsp_q <= MidQ; fst_q <= MidQ; gdl_q <= now + 32'(gap_q);
                step_q <= step_q + 3'd1;
              end else begin
                fsp_q <= nfs; fst_q <= nft;
              end
              if (now > dl) begin
                case (step_q)
                  3'd1: begin sn_q <= lat(nfs); tn_q <= lat(nft); end
                  3'd2: sx_q <= lat(nfs);
                  3'd3: sm_q <= lat(nfs);
                  3'd4: tx_q <= lat(nft);
                  default: begin
                    tm_q <= lat(nft); step_q <= '0; done_q <= 1'b1;
                    // rmax/rmin > 10 with truncation == rmax >= 11*rmin for like signs
                    if (rmin != 0 && ((rmin > 0 && rmax >= 17'sd11 * rmin) ||
                                      (rmin < 0 && rmax <= 17'sd11 * rmin)))
                      sm_q <= sn_q;
                    if (rmax != 0 && ((rmax > 0 && rmin >= 17'sd11 * rmax) ||
                                      (rmax < 0 && rmin <= 17'sd11 * rmax)))
                      sx_q <= sn_q;
                  end
                endcase
              end
            end
          end
        end
        ST_DIV: begin
          if (!div_busy && !div_start) begin
            if (axis_q) begin
              ht_q <= -mapped; ovalid_q <= 1'b1;
            end else begin
              hs_q <= mapped; axis_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) in_q <= s_axis_tdata;
    if (div_start) begin
      d_q <= d_n; rng_q <= r_n;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {6'b0, tm_q, tx_q, tn_q, sm_q, sx_q, sn_q, done_q, step_q,
                         ht_q, hs_q};

  `ASSERT_NEVER(a_no_accept_busy, acc && state_q != ST_IDLE)
  `ASSERT_IMPL(a_step_range, step_q <= 3'd5)
  `ASSERT_IMPL(a_done_idle, done_q && m_axis_tvalid |-> step_q == 3'd0)
endmodule
